/* src/ipt_pkg.sv */
// ----------------------------------------------------------------------------
// ipt_pkg
// Shared types, field widths and command/status bundles for the inverted page
// table translation unit.
// ----------------------------------------------------------------------------
package ipt_pkg;

    // Table geometry and address split
    localparam int DEF_ENTRIES = 1024;
    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int PID_BITS    = 16;
    localparam int VADDR_BITS  = 31;

    // Field widths of the request and response payloads
    localparam int PID_FIELD_W   = 16;
    localparam int VADDR_FIELD_W = 31;
    localparam int PAGE_W        = 19;
    localparam int FRAME_W       = 10;
    localparam int PHYS_W        = 22;

    // Widths actually used after masking
    localparam int PID_W  = (PID_BITS < PID_FIELD_W) ? PID_BITS : PID_FIELD_W;
    localparam int VA_W   = (VADDR_BITS < VADDR_FIELD_W) ? VADDR_BITS : VADDR_FIELD_W;
    localparam int VPN_W  = VA_W - PAGE_SHIFT;
    localparam int CMP_W  = (VPN_W > PAGE_W) ? VPN_W : PAGE_W;
    localparam int SUM_W  = FRAME_W + PAGE_SHIFT;

    typedef enum logic {
        REQ_LOOKUP = 1'b0,
        REQ_ADD    = 1'b1
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        t_req_kind                  req_type;
        logic [PID_FIELD_W-1:0]     proc_id;
        logic [VADDR_FIELD_W-1:0]   virt_addr;
        logic [PAGE_W-1:0]          page_num;
        logic [FRAME_W-1:0]         frame_num;
    } t_req;

    typedef struct packed {
        t_status                    status;
        logic [PHYS_W-1:0]          phys_addr;
    } t_rsp;

    typedef struct packed {
        logic [PID_W-1:0]           pid;
        logic [PAGE_W-1:0]          page;
        logic [FRAME_W-1:0]         frame;
    } t_slot;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture the request, restart the scan
        logic add;      // append the held triple
        logic scan;     // step the lookup scan
        logic emit;     // move the result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic hit;      // compared slot matches
        logic miss;     // no slot left to compare
        logic out_free; // output register can take a result this cycle
    } t_sts;

endpackage

/* src/ipt_ctrl.sv */
// ----------------------------------------------------------------------------
// ipt_ctrl
// Request sequencer: accepts one request, runs the add or the lookup scan in
// the datapath, and hands the result to the output register.
// ----------------------------------------------------------------------------
module ipt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic           i_is_add,
    input  ipt_pkg::t_sts  i_sts,
    output ipt_pkg::t_cmd  o_cmd
);
    import ipt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_is_add ? S_ADD : S_SCAN;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_EMIT;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit || i_sts.miss) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold the result until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_ADD || r_state == S_SCAN))
        else $error("accepted request did not start work");

    a_emit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !i_sts.out_free) |=> (r_state == S_EMIT))
        else $error("result dropped while output register busy");

    a_add_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |=> (r_state == S_EMIT))
        else $error("add did not finish in one cycle");

endmodule

/* src/ipt_dpath.sv */
// ----------------------------------------------------------------------------
// ipt_dpath
// Slot memory, fill count, lookup scan pipeline, result and output registers.
// ----------------------------------------------------------------------------
module ipt_dpath #(
    parameter int ENTRIES = ipt_pkg::DEF_ENTRIES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ipt_pkg::t_req  i_req,
    input  ipt_pkg::t_cmd  i_cmd,
    output ipt_pkg::t_sts  o_sts,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output ipt_pkg::t_rsp  o_out
);
    import ipt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    t_slot                  r_mem [ENTRIES];
    t_slot                  r_rd_data;
    logic                   r_rd_vld;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_idx;

    logic [PID_W-1:0]       r_pid;
    logic [VPN_W-1:0]       r_vpn;
    logic [PAGE_SHIFT-1:0]  r_ofs;
    logic [PAGE_W-1:0]      r_page;
    logic [FRAME_W-1:0]     r_frame;

    t_rsp                   r_res;
    t_rsp                   r_out;
    logic                   r_out_valid;

    logic                   w_room;
    logic                   w_issue;
    logic                   w_match;
    logic [PHYS_W-1:0]      w_phys;
    t_slot                  w_new_slot;

    assign w_room  = (r_count < FULL_CNT);
    assign w_issue = (r_idx < r_count);
    assign w_match = (r_rd_data.pid == r_pid) &&
                     (CMP_W'(r_rd_data.page) == CMP_W'(r_vpn));
    assign w_phys  = PHYS_W'((SUM_W'(r_rd_data.frame) << PAGE_SHIFT) | SUM_W'(r_ofs));

    assign w_new_slot.pid   = r_pid;
    assign w_new_slot.page  = r_page;
    assign w_new_slot.frame = r_frame;

    assign o_sts.hit      = r_rd_vld && w_match;
    assign o_sts.miss     = !r_rd_vld && !w_issue;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.add && w_room) begin
            r_mem[r_count[IDX_W-1:0]] <= w_new_slot;
        end
        r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pid   <= i_req.proc_id[PID_W-1:0];
            r_vpn   <= i_req.virt_addr[VA_W-1:PAGE_SHIFT];
            r_ofs   <= i_req.virt_addr[PAGE_SHIFT-1:0];
            r_page  <= i_req.page_num;
            r_frame <= i_req.frame_num;
        end
        if (i_cmd.add) begin
            r_res.status    <= w_room ? ST_OK : ST_FULL;
            r_res.phys_addr <= '0;
        end else if (i_cmd.scan && o_sts.hit) begin
            r_res.status    <= ST_OK;
            r_res.phys_addr <= w_phys;
        end else if (i_cmd.scan && o_sts.miss) begin
            r_res.status    <= ST_MISS;
            r_res.phys_addr <= '0;
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.add && w_room) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.load) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                // advance one slot a cycle; the compare works on the registered read data
                r_rd_vld <= w_issue;
                if (w_issue) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("fill count beyond table size");

    a_scan_within_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_count)
        else $error("scan index past filled slots");

    a_read_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_idx != '0))
        else $error("compare without an issued read");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> o_sts.out_free)
        else $error("result emitted over a pending one");

endmodule

/* src/inverted_page_table_unit.sv */
// ----------------------------------------------------------------------------
// inverted_page_table_unit
// Inverted page table: add (pid, page, frame) triples, translate
// (pid, virtual address) to a physical address.
// ----------------------------------------------------------------------------
// One request is handled at a time. Slots fill in order and are never freed,
// so a fill count marks the valid slots and no clearing pass runs after
// reset. A lookup walks the filled slots through the single read port of the
// slot memory, one slot per cycle with the compare in the cycle after the
// read, up to the first match, or through all filled slots on a miss. The
// result sits in an output register, and a new request is taken while it
// waits to be collected.
// ----------------------------------------------------------------------------
module inverted_page_table_unit #(
    parameter int ENTRIES = ipt_pkg::DEF_ENTRIES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ipt_pkg::t_req  i_req,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output ipt_pkg::t_rsp  o_rsp
);
    import ipt_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    ipt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_is_add   (i_req.req_type == REQ_ADD),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ipt_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_rsp)
    );

endmodule

/* verif/ipt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipt_checker
// Watches both channels of the inverted page table unit. It keeps its own copy
// of the slot table, works out the response to every accepted request and
// compares each delivered response against the oldest one still waiting.
// ----------------------------------------------------------------------------
module ipt_checker #(
    parameter int SLOTS = ipt_pkg::DEF_ENTRIES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  ipt_pkg::t_req  i_req,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  ipt_pkg::t_rsp  i_rsp,
    output int             o_errors,
    output int             o_pending
);
    import ipt_pkg::*;

    // Slots fill in order and are never freed, so the fill count is the valid map
    logic [PID_W-1:0]   slot_pid   [SLOTS];
    logic [PAGE_W-1:0]  slot_page  [SLOTS];
    logic [FRAME_W-1:0] slot_frame [SLOTS];
    int                 slots_used = 0;
    t_rsp               expected_rsp_q[$];
    int                 error_count = 0;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic t_rsp predict_translation(input t_req r);
        t_rsp             rsp;
        logic [PID_W-1:0] pid;
        logic [63:0]      va;
        logic [63:0]      vpn;
        logic [63:0]      offset;
        pid           = r.proc_id[PID_W-1:0];
        rsp.phys_addr = '0;
        if (r.req_type == REQ_ADD) begin
            rsp.status = ST_FULL;
            if (slots_used < SLOTS) begin
                slot_pid[slots_used]   = pid;
                slot_page[slots_used]  = r.page_num;
                slot_frame[slots_used] = r.frame_num;
                slots_used++;
                rsp.status = ST_OK;
            end
        end else begin
            va     = 64'(r.virt_addr[VA_W-1:0]);
            vpn    = va / PAGE_BYTES;
            offset = va % PAGE_BYTES;
            rsp.status = ST_MISS;
            // first match in slot order wins
            for (int i = 0; i < slots_used; i++) begin
                if (slot_pid[i] == pid && 64'(slot_page[i]) == vpn) begin
                    rsp.status    = ST_OK;
                    rsp.phys_addr = PHYS_W'(64'(slot_frame[i]) * PAGE_BYTES + offset);
                    break;
                end
            end
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            slots_used = 0;
            expected_rsp_q.delete();
        end else begin
            // a response never belongs to the request taken at the same edge
            if (i_out_valid && !i_out_stall) begin
                if (expected_rsp_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected response status=%0d phys=%h",
                                              i_rsp.status, i_rsp.phys_addr));
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (i_rsp.status !== want.status) begin
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  i_rsp.status, want.status));
                    end
                    if (i_rsp.phys_addr !== want.phys_addr) begin
                        report_mismatch($sformatf("phys_addr got %h want %h",
                                                  i_rsp.phys_addr, want.phys_addr));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_rsp_q.push_back(predict_translation(i_req));
            end
        end
        o_pending <= expected_rsp_q.size();
        o_errors  <= error_count;
    end

endmodule

/* verif/tb_inverted_page_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_inverted_page_table_unit
// Drives adds and lookups into the inverted page table unit: a directed
// opening, then random traffic under changing idle and stall rates.
// ----------------------------------------------------------------------------
module tb_inverted_page_table_unit;
    import ipt_pkg::*;

    localparam int N_SLOTS     = DEF_ENTRIES;
    localparam int CYCLE_LIMIT = 8_000_000;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    t_req req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    t_rsp rsp;

    int   error_count;
    int   pending_count;
    int   cycle_count   = 0;
    int   req_idle_pct  = 0;
    int   rsp_stall_pct = 0;
    int   added_count   = 0;

    // keys known to be in the table, used to aim lookups at hits
    t_slot known_keys[$];

    logic [PID_FIELD_W-1:0] hot_pids [6] = '{16'h0000, 16'h0001, 16'h8000,
                                            16'hFFFF, 16'h5A5A, 16'h1234};

    inverted_page_table_unit #(
        .ENTRIES (N_SLOTS)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_req       (req),
        .o_out_valid (rsp_valid),
        .i_out_stall (rsp_stall),
        .o_rsp       (rsp)
    );

    ipt_checker #(
        .SLOTS (N_SLOTS)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .i_in_stall  (req_stall),
        .i_req       (req),
        .i_out_valid (rsp_valid),
        .i_out_stall (rsp_stall),
        .i_rsp       (rsp),
        .o_errors    (error_count),
        .o_pending   (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end

    function automatic t_req make_req(input t_req_kind kind,
                                      input logic [PID_FIELD_W-1:0] pid,
                                      input logic [VADDR_FIELD_W-1:0] va,
                                      input logic [PAGE_W-1:0] page,
                                      input logic [FRAME_W-1:0] frame);
        t_req r;
        r.req_type  = kind;
        r.proc_id   = pid;
        r.virt_addr = va;
        r.page_num  = page;
        r.frame_num = frame;
        return r;
    endfunction

    function automatic t_req random_req(input int add_pct);
        t_req  r;
        t_slot key;
        int    sel;
        r.req_type  = ($urandom_range(99) < add_pct) ? REQ_ADD : REQ_LOOKUP;
        r.proc_id   = ($urandom_range(99) < 70) ? hot_pids[$urandom_range(5)]
                                                : PID_FIELD_W'($urandom);
        r.virt_addr = VADDR_FIELD_W'($urandom);
        r.page_num  = PAGE_W'($urandom);
        r.frame_num = FRAME_W'($urandom);
        if (known_keys.size() > 0) begin
            key = known_keys[$urandom_range(known_keys.size() - 1)];
            sel = $urandom_range(99);
            if (r.req_type == REQ_LOOKUP) begin
                if (sel < 65) begin
                    r.proc_id   = key.pid;
                    r.virt_addr = {key.page, PAGE_SHIFT'($urandom)};
                end else if (sel < 80) begin
                    // right page, most likely another process
                    r.virt_addr = {key.page, PAGE_SHIFT'($urandom)};
                end else if (sel < 90) begin
                    // right process, page off by one bit
                    r.proc_id   = key.pid;
                    r.virt_addr = {key.page ^ (PAGE_W'(1) << $urandom_range(PAGE_W - 1)),
                                   PAGE_SHIFT'($urandom)};
                end
            end else if (sel < 15) begin
                // duplicate key with a fresh frame
                r.proc_id  = key.pid;
                r.page_num = key.page;
            end
        end
        return r;
    endfunction

    task automatic send_request(input t_req r);
        t_slot key;
        if ($urandom_range(99) < req_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < req_idle_pct) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        if (r.req_type == REQ_ADD && added_count < N_SLOTS) begin
            key.pid   = r.proc_id[PID_W-1:0];
            key.page  = r.page_num;
            key.frame = r.frame_num;
            known_keys.push_back(key);
            added_count++;
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    req_idle_pct  = 30;
                    rsp_stall_pct = 86;
                end
                1: begin
                    req_idle_pct  = 86;
                    rsp_stall_pct = 30;
                end
                default: begin
                    req_idle_pct  = 0;
                    rsp_stall_pct = 0;
                end
            endcase

            if (phase == 0) begin
                send_request(make_req(REQ_LOOKUP, 16'h0000, 31'h0, 19'h0, 10'h0));
                send_request(make_req(REQ_ADD, 16'h0000, 31'h7FFF_FFFF, 19'h0, 10'h0));
                send_request(make_req(REQ_ADD, 16'hFFFF, 31'h0, 19'h7FFFF, 10'h3FF));
                send_request(make_req(REQ_LOOKUP, 16'hFFFF, 31'h7FFF_FFFF, 19'h0, 10'h0));
                send_request(make_req(REQ_LOOKUP, 16'h0000, 31'h0, 19'h7FFFF, 10'h3FF));
                send_request(make_req(REQ_ADD, 16'h0000, 31'h0, 19'h0, 10'h155));
                send_request(make_req(REQ_LOOKUP, 16'h0000, 31'h0000_0ABC, 19'h0, 10'h0));
                send_request(make_req(REQ_LOOKUP, 16'h0001, 31'h0, 19'h0, 10'h0));
                send_request(make_req(REQ_LOOKUP, 16'hFFFF, 31'h0, 19'h0, 10'h0));
                send_request(make_req(REQ_LOOKUP, 16'h0000, {19'h7FFFF, 12'h0}, 19'h0, 10'h0));
                send_request(make_req(REQ_ADD, 16'h8000, 31'h2AAA_AAAA, 19'h40000, 10'h200));
                send_request(make_req(REQ_LOOKUP, 16'h8000, {19'h40000, 12'hFFF},
                                      19'h7FFFF, 10'h3FF));
                send_request(make_req(REQ_ADD, 16'h1234, 31'h5555_5555, 19'h2AAAA, 10'h2AA));
                send_request(make_req(REQ_LOOKUP, 16'h1234, {19'h2AAAA, 12'h555},
                                      19'h55555, 10'h155));
                send_request(make_req(REQ_LOOKUP, 16'hFFFF, {19'h7FFFF, 12'h0}, 19'h0, 10'h0));
                send_request(make_req(REQ_LOOKUP, 16'h0000, 31'h7FFF_FFFF, 19'h0, 10'h0));
            end

            for (int n = 0; n < 188; n++) begin
                send_request(random_req(40));
            end
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (N_SLOTS + 8) @(posedge clk);
        if (error_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
src/ipt_pkg.sv
src/ipt_ctrl.sv
src/ipt_dpath.sv
src/inverted_page_table_unit.sv
verif/ipt_checker.sv
verif/tb_inverted_page_table_unit.sv
